/* src/ecis_pkg.sv */
// Shared types and constants for the event combiner and interrupt selector.
// Used by ecis_route, ecis_regs and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ecis_pkg;

   localparam int NUM_WORDS = 4;
   localparam int NUM_SEL   = 12;
   localparam int SEL_WIDTH = 7;
   localparam int IRQ_BASE  = 4;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_EVENT = 2'd2;

   // Register regions, selected by byte offset bits 8 to 4.
   localparam logic [4:0] REGION_FLAGS    = 5'h00;
   localparam logic [4:0] REGION_SET      = 5'h02;
   localparam logic [4:0] REGION_CLEAR    = 5'h04;
   localparam logic [4:0] REGION_MASK     = 5'h08;
   localparam logic [4:0] REGION_COMBINED = 5'h0A;
   localparam logic [4:0] REGION_SELECT   = 5'h10;

   localparam logic [31:0] MASK0_FORCED = 32'h0000_000F;

   typedef logic [NUM_SEL-1:0][SEL_WIDTH-1:0] sel_array_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [8:0]  offset;
      logic [31:0] data;
      logic [7:0]  line;
   } cmd_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        access_error;
      logic        irq_hit;
      logic [3:0]  irq_number;
   } result_type;

endpackage

`default_nettype wire

/* src/ecis_route.sv */
// Selector match: finds the first route selector equal to the routed number.
// Depends on ecis_pkg for the selector array type.
`timescale 1ns / 1ps
`default_nettype none

module ecis_route (
   input  wire ecis_pkg::sel_array_type selectors,
   input  wire logic [6:0]              route_num,
   output logic                         hit,
   output logic [3:0]                   irq_number
);
   import ecis_pkg::*;

   always_comb begin
      hit        = 1'b0;
      irq_number = 4'd0;
      for (int k = NUM_SEL - 1; k >= 0; k--) begin
         if (selectors[k] == route_num) begin
            hit        = 1'b1;
            irq_number = 4'(IRQ_BASE + k);
         end
      end
   end

endmodule

`default_nettype wire

/* src/ecis_regs.sv */
// Register file of the block: event flags, masks, combined flags and selectors,
// with bus decode and event handling. Depends on ecis_pkg and ecis_route.
`timescale 1ns / 1ps
`default_nettype none

module ecis_regs (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                enable,
   input  wire ecis_pkg::cmd_type    cmd,
   output ecis_pkg::result_type     result
);
   import ecis_pkg::*;

   logic [NUM_WORDS-1:0][31:0] flags_ff, flags_in;
   logic [NUM_WORDS-1:0][31:0] masks_ff, masks_in;
   logic [NUM_WORDS-1:0][31:0] combined_ff, combined_in;
   sel_array_type              sel_ff, sel_in;

   logic [4:0]  region;
   logic [1:0]  word;
   logic [1:0]  sel_word;
   logic        aligned;
   logic        line_ok;
   logic [1:0]  ev_word;
   logic [4:0]  ev_bit;
   logic        ev_masked;
   logic [6:0]  route_num;
   logic        route_hit;
   logic [3:0]  route_irq;
   logic [31:0] sel_read;

   assign region    = cmd.offset[8:4];
   assign word      = cmd.offset[3:2];
   assign sel_word  = word - 2'd1;
   assign aligned   = (cmd.offset[1:0] == 2'd0);
   assign line_ok   = !cmd.line[7] && (cmd.line[6:2] != 5'd0);
   assign ev_word   = cmd.line[6:5];
   assign ev_bit    = cmd.line[4:0];
   assign ev_masked = masks_ff[ev_word][ev_bit];
   assign route_num = ev_masked ? cmd.line[6:0] : {5'd0, ev_word};

   always_comb begin
      sel_read = '0;
      for (int j = 0; j < 4; j++) begin
         sel_read[8*j +: SEL_WIDTH] = sel_ff[{sel_word, 2'(j)}];
      end
   end

   ecis_route u_route (
      .selectors  (sel_ff),
      .route_num  (route_num),
      .hit        (route_hit),
      .irq_number (route_irq)
   );

   always_comb begin
      flags_in    = flags_ff;
      masks_in    = masks_ff;
      combined_in = combined_ff;
      sel_in      = sel_ff;
      result      = '0;
      case (cmd.op)
         OP_READ: begin
            result.access_error = 1'b1;
            if (aligned) begin
               case (region)
                  REGION_FLAGS: begin
                     result.read_data    = flags_ff[word];
                     result.access_error = 1'b0;
                  end
                  REGION_MASK: begin
                     result.read_data    = masks_ff[word];
                     result.access_error = 1'b0;
                  end
                  REGION_COMBINED: begin
                     result.read_data    = combined_ff[word];
                     result.access_error = 1'b0;
                  end
                  REGION_SELECT: begin
                     if (word != 2'd0) begin
                        result.read_data    = sel_read;
                        result.access_error = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         OP_WRITE: begin
            result.access_error = 1'b1;
            if (aligned) begin
               case (region)
                  REGION_SET: begin
                     flags_in[word]      = flags_ff[word] | cmd.data;
                     result.access_error = 1'b0;
                  end
                  REGION_CLEAR: begin
                     flags_in[word]      = flags_ff[word] & ~cmd.data;
                     combined_in[word]   = combined_ff[word] & ~cmd.data;
                     result.access_error = 1'b0;
                  end
                  REGION_MASK: begin
                     masks_in[word] = (word == 2'd0) ? (cmd.data | MASK0_FORCED)
                                                     : cmd.data;
                     result.access_error = 1'b0;
                  end
                  REGION_SELECT: begin
                     if (word != 2'd0) begin
                        for (int j = 0; j < 4; j++) begin
                           sel_in[{sel_word, 2'(j)}] = cmd.data[8*j +: SEL_WIDTH];
                        end
                        result.access_error = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         OP_EVENT: begin
            if (line_ok) begin
               if (!ev_masked) begin
                  combined_in[ev_word][ev_bit] = 1'b1;
               end
               result.irq_hit    = route_hit;
               result.irq_number = route_irq;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff    <= '0;
         for (int k = 0; k < NUM_WORDS; k++) begin
            masks_ff[k] <= (k == 0) ? MASK0_FORCED : 32'd0;
         end
         combined_ff <= '0;
         for (int k = 0; k < NUM_SEL; k++) begin
            sel_ff[k] <= SEL_WIDTH'(IRQ_BASE + k);
         end
      end else if (enable) begin
         flags_ff    <= flags_in;
         masks_ff    <= masks_in;
         combined_ff <= combined_in;
         sel_ff      <= sel_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      masks_ff[0][3:0] == 4'hF)
      else $error("Mask word 0 lost its forced low bits.");

   assert property (@(posedge clock) disable iff (reset)
      (enable && cmd.op == OP_WRITE && aligned && region == REGION_CLEAR)
      |=> ((flags_ff[$past(word)] & $past(cmd.data)) == 32'd0) &&
          ((combined_ff[$past(word)] & $past(cmd.data)) == 32'd0))
      else $error("A clear transfer left flag bits set.");

   assert property (@(posedge clock) disable iff (reset)
      (enable && cmd.op == OP_EVENT && line_ok && !ev_masked)
      |=> combined_ff[$past(ev_word)][$past(ev_bit)])
      else $error("An unmasked event did not set its combined flag.");

   assert property (@(posedge clock) disable iff (reset)
      (enable && cmd.op == OP_READ) |=> $stable(sel_ff) && $stable(flags_ff))
      else $error("A read transfer changed register state.");
`endif

endmodule

`default_nettype wire

/* src/event_combiner_interrupt_selector.sv */
// Top level of the event combiner and interrupt selector: input register,
// output register and the register file. Depends on ecis_pkg and ecis_regs.
//
// Usage: each request transfer carries a bus read, a bus write or an event
// arrival. Every request yields exactly one response transfer with the read
// data, an access error flag and, for events, the interrupt raised and the
// core that receives it. Requests are taken into an input register; the
// decode, register update and selector match run on the held request and the
// outcome is loaded into the output register once that register is empty or
// its response is taken. rsp_valid rises when the outcome is loaded, and
// one request is accepted every cycle while responses are taken. When the
// receiver stalls, the output register holds its response and the input
// register holds one further request, after which req_ready falls until
// rsp_ready returns. State is updated only when a request leaves the input
// register, so updates follow request order.
// Reset empties both registers, clears all flags, sets mask word 0 to 0xF and
// loads selector k with 4 plus k.
`timescale 1ns / 1ps
`default_nettype none

module event_combiner_interrupt_selector #(
   parameter int CORE_COUNT = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [8:0]  req_bus_offset,
   input  wire logic [31:0] req_write_data,
   input  wire logic [7:0]  req_event_line,
   input  wire logic [2:0]  req_core_id,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_read_data,
   output logic             rsp_access_error,
   output logic             rsp_irq_valid,
   output logic [3:0]       rsp_irq_number,
   output logic [2:0]       rsp_irq_core
);
   import ecis_pkg::*;

   logic       in_valid_ff;
   cmd_type    in_cmd_ff, in_cmd_in;
   logic [2:0] in_core_ff;
   logic       out_valid_ff;
   logic [31:0] out_read_data_ff;
   logic       out_error_ff;
   logic       out_irq_valid_ff, out_irq_valid_in;
   logic [3:0] out_irq_number_ff;
   logic [2:0] out_irq_core_ff;
   logic       advance;
   logic       core_ok;
   result_type result;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign in_cmd_in = '{op: req_op, offset: req_bus_offset, data: req_write_data,
                        line: req_event_line};

   ecis_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .cmd    (in_cmd_ff),
      .result (result)
   );

   assign core_ok          = (32'(in_core_ff) < CORE_COUNT);
   assign out_irq_valid_in = result.irq_hit && core_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff  <= in_cmd_in;
         in_core_ff <= req_core_id;
      end
      if (advance) begin
         out_read_data_ff  <= result.read_data;
         out_error_ff      <= result.access_error;
         out_irq_valid_ff  <= out_irq_valid_in;
         out_irq_number_ff <= out_irq_valid_in ? result.irq_number : 4'd0;
         out_irq_core_ff   <= out_irq_valid_in ? in_core_ff : 3'd0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_data    = out_read_data_ff;
   assign rsp_access_error = out_error_ff;
   assign rsp_irq_valid    = out_irq_valid_ff;
   assign rsp_irq_number   = out_irq_number_ff;
   assign rsp_irq_core     = out_irq_core_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_access_error) |-> (rsp_read_data == 32'd0) && !rsp_irq_valid)
      else $error("An errored response carries data or an interrupt.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_irq_valid) |-> (rsp_irq_number >= 4'd4))
      else $error("An interrupt number below four was raised.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_read_data))
      else $error("A stalled response was dropped or changed.");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_cmd_ff))
      else $error("A held request was lost before processing.");
`endif

endmodule

`default_nettype wire

/* bench/ecis_tb_pkg.sv */
// Scoreboard for the event combiner and interrupt selector bench: a predictor of the
// flag, mask, combined-flag and selector state and a queue of expected response transfers.
// Depends on ecis_pkg.
`timescale 1ns / 1ps

package ecis_tb_pkg;
   import ecis_pkg::*;

   localparam int TB_CORE_COUNT = 8;
   localparam int FIRST_EVENT   = 4;
   localparam int EVENT_LIMIT   = 128;

   typedef struct packed {
      logic [31:0] read_data;
      logic        access_error;
      logic        irq_valid;
      logic [3:0]  irq_number;
      logic [2:0]  irq_core;
   } response_type;

   class ecis_scoreboard;
      logic [31:0]          event_flags [NUM_WORDS];
      logic [31:0]          event_masks [NUM_WORDS];
      logic [31:0]          combined_flags [NUM_WORDS];
      logic [SEL_WIDTH-1:0] selectors [NUM_SEL];
      response_type         expected_responses [$];
      int unsigned          failures;

      function new();
         int k;
         for (k = 0; k < NUM_WORDS; k++) begin
            event_flags[k]    = '0;
            event_masks[k]    = '0;
            combined_flags[k] = '0;
         end
         event_masks[0] = MASK0_FORCED;
         for (k = 0; k < NUM_SEL; k++)
            selectors[k] = SEL_WIDTH'(IRQ_BASE + k);
         failures = 0;
      endfunction

      function int pending_count();
         return expected_responses.size();
      endfunction

      // The lowest-numbered matching selector wins, hence the downward scan.
      function logic [3:0] route_irq(input logic [SEL_WIDTH-1:0] target);
         int k;
         route_irq = '0;
         for (k = NUM_SEL - 1; k >= 0; k--)
            if (selectors[k] == target)
               route_irq = 4'(IRQ_BASE + k);
      endfunction

      function logic [31:0] selector_word(input int idx);
         int j;
         selector_word = '0;
         for (j = 0; j < 4; j++)
            selector_word[8*j +: SEL_WIDTH] = selectors[4*idx + j];
      endfunction

      function void note_request(input logic [1:0] op, input logic [8:0] offset,
                                 input logic [31:0] data, input logic [7:0] line,
                                 input logic [2:0] core);
         response_type rsp;
         logic [4:0]   region;
         logic [1:0]   group;
         logic [4:0]   bit_pos;
         logic [3:0]   irq;
         logic         mapped;
         int           w, j;
         rsp     = '0;
         region  = offset[8:4];
         w       = offset[3:2];
         group   = line[6:5];
         bit_pos = line[4:0];
         mapped  = 1'b0;
         if (op == OP_READ) begin
            if (offset[1:0] == 2'b00) begin
               case (region)
                  REGION_FLAGS: begin
                     rsp.read_data = event_flags[w];
                     mapped = 1'b1;
                  end
                  REGION_MASK: begin
                     rsp.read_data = event_masks[w];
                     mapped = 1'b1;
                  end
                  REGION_COMBINED: begin
                     rsp.read_data = combined_flags[w];
                     mapped = 1'b1;
                  end
                  REGION_SELECT: begin
                     if (w != 0) begin
                        rsp.read_data = selector_word(w - 1);
                        mapped = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            rsp.access_error = !mapped;
         end else if (op == OP_WRITE) begin
            if (offset[1:0] == 2'b00) begin
               case (region)
                  REGION_SET: begin
                     event_flags[w] |= data;
                     mapped = 1'b1;
                  end
                  REGION_CLEAR: begin
                     event_flags[w]    &= ~data;
                     combined_flags[w] &= ~data;
                     mapped = 1'b1;
                  end
                  REGION_MASK: begin
                     event_masks[w] = (w == 0) ? (data | MASK0_FORCED) : data;
                     mapped = 1'b1;
                  end
                  REGION_SELECT: begin
                     if (w != 0) begin
                        for (j = 0; j < 4; j++)
                           selectors[4*(w - 1) + j] = data[8*j +: SEL_WIDTH];
                        mapped = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            rsp.access_error = !mapped;
         end else if (op == OP_EVENT) begin
            if (line >= FIRST_EVENT && line < EVENT_LIMIT) begin
               if (!event_masks[group][bit_pos]) begin
                  combined_flags[group][bit_pos] = 1'b1;
                  irq = route_irq(SEL_WIDTH'(group));
               end else begin
                  irq = route_irq(line[SEL_WIDTH-1:0]);
               end
               if (irq != 0 && core < TB_CORE_COUNT) begin
                  rsp.irq_valid  = 1'b1;
                  rsp.irq_number = irq;
                  rsp.irq_core   = core;
               end
            end
         end
         expected_responses.push_back(rsp);
      endfunction

      function void compare_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_response(input logic [31:0] read_data, input logic access_error,
                                   input logic irq_valid, input logic [3:0] irq_number,
                                   input logic [2:0] irq_core);
         response_type want;
         if (expected_responses.size() == 0) begin
            $display("%0t: response transfer with none expected, expected none, actual %h",
                     $time, read_data);
            failures++;
            return;
         end
         want = expected_responses.pop_front();
         compare_field("read_data", want.read_data, read_data);
         compare_field("access_error", 32'(want.access_error), 32'(access_error));
         compare_field("irq_valid", 32'(want.irq_valid), 32'(irq_valid));
         compare_field("irq_number", 32'(want.irq_number), 32'(irq_number));
         compare_field("irq_core", 32'(want.irq_core), 32'(irq_core));
      endfunction
   endclass

endpackage

/* bench/tb_top.sv */
// Top level of the event combiner and interrupt selector bench: clock, reset, request
// and response drivers with random idling, directed and random traffic.
// Depends on ecis_pkg, ecis_tb_pkg and the block under test.
`timescale 1ns / 1ps

module tb_top;
   import ecis_pkg::*;
   import ecis_tb_pkg::*;

   localparam int         TRAFFIC_ITEMS = 1350;
   localparam logic [8:0] OFFSET_TOP    = 9'h1FF;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op         = OP_READ;
   logic [8:0]  req_bus_offset = '0;
   logic [31:0] req_write_data = '0;
   logic [7:0]  req_event_line = '0;
   logic [2:0]  req_core_id    = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_access_error;
   logic        rsp_irq_valid;
   logic [3:0]  rsp_irq_number;
   logic [2:0]  rsp_irq_core;

   ecis_scoreboard ledger = new();
   bit req_calm  = 1'b0;
   bit rsp_calm  = 1'b0;
   int rsp_hold  = 0;

   always #10 clock = ~clock;

   event_combiner_interrupt_selector #(.CORE_COUNT(TB_CORE_COUNT)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_bus_offset(req_bus_offset),
      .req_write_data(req_write_data),
      .req_event_line(req_event_line),
      .req_core_id(req_core_id),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_access_error(rsp_access_error),
      .rsp_irq_valid(rsp_irq_valid),
      .rsp_irq_number(rsp_irq_number),
      .rsp_irq_core(rsp_irq_core)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 2);
      if (r < 95)
         return $urandom_range(3, 6);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [8:0] reg_offset(input logic [4:0] region, input int word);
      return {region, 2'(word), 2'b00};
   endfunction

   task automatic transfer_request(input logic [1:0] op, input logic [8:0] offset,
                                   input logic [31:0] data, input logic [7:0] line,
                                   input logic [2:0] core);
      int gap;
      req_valid      <= 1'b1;
      req_op         <= op;
      req_bus_offset <= offset;
      req_write_data <= data;
      req_event_line <= line;
      req_core_id    <= core;
      do @(posedge clock); while (!req_ready);
      ledger.note_request(op, offset, data, line, core);
      if ($urandom_range(0, 99) == 0)
         req_calm = !req_calm;
      gap = (!req_calm && $urandom_range(0, 1) != 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_response(rsp_read_data, rsp_access_error, rsp_irq_valid,
                               rsp_irq_number, rsp_irq_core);
      if ($urandom_range(0, 149) == 0)
         rsp_calm = !rsp_calm;
      if (rsp_hold > 0) begin
         rsp_hold--;
      end else if (rsp_calm || $urandom_range(0, 2) != 0) begin
         rsp_ready <= 1'b1;
         rsp_hold = $urandom_range(0, 7);
      end else begin
         rsp_ready <= 1'b0;
         rsp_hold = pick_gap() - 1;
      end
   end

   initial begin
      logic [1:0]  op;
      logic [8:0]  offset;
      logic [31:0] data;
      logic [7:0]  line;
      logic [2:0]  core;
      logic [4:0]  region;
      int          n, j, pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      transfer_request(OP_READ, reg_offset(REGION_SELECT, 1), '0, '0, 3'd0);
      transfer_request(OP_READ, reg_offset(REGION_MASK, 0), '0, '0, 3'd0);
      transfer_request(OP_EVENT, '0, '0, 8'd4, 3'd0);
      transfer_request(OP_READ, reg_offset(REGION_COMBINED, 0), '0, '0, 3'd0);
      transfer_request(OP_WRITE, reg_offset(REGION_MASK, 0), 32'h0000_0000, '0, 3'd0);
      transfer_request(OP_READ, reg_offset(REGION_MASK, 0), '0, '0, 3'd0);
      transfer_request(OP_WRITE, reg_offset(REGION_MASK, 0), 32'h0000_0030, '0, 3'd0);
      transfer_request(OP_EVENT, '0, '0, 8'd4, 3'd7);
      transfer_request(OP_EVENT, '0, '0, 8'd3, 3'd1);
      transfer_request(OP_EVENT, '0, '0, 8'd128, 3'd1);
      transfer_request(OP_EVENT, OFFSET_TOP, '1, 8'd255, 3'd7);
      transfer_request(OP_WRITE, reg_offset(REGION_SELECT, 1), 32'h0000_0003, '0, 3'd0);
      transfer_request(OP_EVENT, '0, '0, 8'd127, 3'd5);
      transfer_request(OP_WRITE, reg_offset(REGION_SELECT, 3), 32'hFFFF_FFFF, '0, 3'd0);
      transfer_request(OP_READ, reg_offset(REGION_SELECT, 3), '0, '0, 3'd0);
      transfer_request(OP_WRITE, reg_offset(REGION_MASK, 3), 32'hFFFF_FFFF, '0, 3'd0);
      transfer_request(OP_EVENT, '0, '0, 8'd127, 3'd2);
      transfer_request(OP_WRITE, reg_offset(REGION_SET, 0), 32'hFFFF_FFFF, '0, 3'd0);
      transfer_request(OP_WRITE, reg_offset(REGION_CLEAR, 3), 32'h8000_FFFF, '0, 3'd0);
      transfer_request(OP_READ, reg_offset(REGION_FLAGS, 0), '0, '0, 3'd0);
      transfer_request(OP_READ, reg_offset(REGION_SET, 2), '0, '0, 3'd0);
      transfer_request(OP_WRITE, reg_offset(REGION_FLAGS, 1), 32'h1234_5678, '0, 3'd0);
      transfer_request(OP_WRITE, reg_offset(REGION_COMBINED, 0), '1, '0, 3'd0);
      transfer_request(OP_READ, reg_offset(REGION_SELECT, 0), '0, '0, 3'd0);
      transfer_request(OP_READ, reg_offset(REGION_MASK, 1) + 9'd1, '0, '0, 3'd0);
      transfer_request(OP_WRITE, OFFSET_TOP, '1, '0, 3'd0);

      for (n = 0; n < TRAFFIC_ITEMS; n++) begin
         pick   = $urandom_range(0, 99);
         core   = 3'($urandom_range(0, 7));
         offset = 9'($urandom_range(0, 511));
         data   = $urandom;
         line   = 8'($urandom_range(0, 255));
         if (pick < 40) begin
            op = OP_EVENT;
            pick = $urandom_range(0, 9);
            if (pick < 4)
               line = 8'($urandom_range(FIRST_EVENT, EVENT_LIMIT - 1));
            else if (pick < 8)
               line = {1'b0, ledger.selectors[$urandom_range(0, NUM_SEL - 1)]};
         end else begin
            op = (pick < 70) ? OP_WRITE : OP_READ;
            if ($urandom_range(0, 9) < 8) begin
               case ($urandom_range(0, 5))
                  0: region = REGION_FLAGS;
                  1: region = REGION_SET;
                  2: region = REGION_CLEAR;
                  3: region = REGION_MASK;
                  4: region = REGION_COMBINED;
                  default: region = REGION_SELECT;
               endcase
               offset = reg_offset(region, $urandom_range(0, 3));
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               data = '0;
            end else if (pick == 1) begin
               data = '1;
            end else if (pick < 6 && offset[8:4] == REGION_SELECT) begin
               for (j = 0; j < 4; j++)
                  data[8*j +: 8] = ($urandom_range(0, 1) != 0) ?
                                   8'($urandom_range(0, NUM_WORDS - 1)) :
                                   8'($urandom_range(0, 255));
            end
         end
         transfer_request(op, offset, data, line, core);
      end
      req_valid <= 1'b0;

      while (ledger.pending_count() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (ledger.failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("%0t: run did not finish in time", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* sim.f */
src/ecis_pkg.sv
src/ecis_route.sv
src/ecis_regs.sv
src/event_combiner_interrupt_selector.sv
bench/ecis_tb_pkg.sv
bench/tb_top.sv
